>>> sv/tws_pkg.sv
// Shared types and constants for the throughput window statistics block.
// No dependencies.
package tws_pkg;

  localparam int unsigned NumWin    = 3;
  localparam int unsigned RunMsW    = 27;
  localparam int unsigned CountW    = 20;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PhaseW    = 4;

  localparam logic [DataW-1:0]  TickMs    = 32'd100;
  localparam logic [PhaseW-1:0] PhaseLast = 4'd9;
  localparam logic [PhaseW-1:0] PhaseHalf = 4'd5;

  // window index
  localparam int unsigned Win100ms = 0;
  localparam int unsigned Win500ms = 1;
  localparam int unsigned Win1s    = 2;

  // x / 1000 == (x * RecipMul) >> RecipShift for every 32-bit x
  localparam logic [DataW-1:0] RecipMul   = 32'd2199023256;
  localparam int unsigned      RecipShift = 41;
  localparam int unsigned      SpeedW     = 2 * DataW - RecipShift;

  localparam logic [0:0] CmdBytes = 1'b0;
  localparam logic [0:0] CmdTick  = 1'b1;

  typedef struct packed {
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] avg;
  } stats_t;

  // classified word from front to back
  typedef struct packed {
    logic [NumWin-1:0]             sample;
    logic [NumWin-1:0][DataW-1:0]  scaled;
    logic                          done;
  } mid_entry_t;

  typedef struct packed {
    stats_t [NumWin-1:0] win;
    logic                finished;
  } result_t;

endpackage

>>> sv/tws_fifo.sv
// Small register queue with full/empty flags.
// Generic; used between front and back and on the result side.
module tws_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/tws_front.sv
// Front end: takes words, keeps byte total, time, tick phase and done flag,
// and hands per-window scaled byte deltas to the back end. Uses tws_pkg.
module tws_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tws_pkg::RunMsW-1:0]    cfg_run_ms_i,
  input  logic                          accept_i,
  input  logic                          command_i,
  input  logic [tws_pkg::CountW-1:0]    byte_count_i,
  output tws_pkg::mid_entry_t           entry_o
);

  import tws_pkg::*;

  logic [RunMsW-1:0]  run_ms_q;
  logic [DataW-1:0]   total_q, total_d;
  logic [DataW-1:0]   elapsed_q, elapsed_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic               done_q, done_d;
  logic [DataW-1:0]   last_q [NumWin];
  logic [DataW-1:0]   delta [NumWin];
  logic [NumWin-1:0]  sample;

  always_comb begin
    total_d   = total_q;
    elapsed_d = elapsed_q;
    phase_d   = phase_q;
    done_d    = done_q;
    sample    = '0;
    if (!done_q) begin
      if (command_i == CmdBytes) begin
        total_d = total_q + DataW'(byte_count_i);
      end else begin
        elapsed_d = elapsed_q + TickMs;
        phase_d   = (phase_q == PhaseLast) ? '0 : phase_q + 1'b1;
        sample[Win100ms] = 1'b1;
        sample[Win500ms] = (phase_d == '0) || (phase_d == PhaseHalf);
        sample[Win1s]    = (phase_d == '0);
        done_d = (elapsed_d == DataW'(run_ms_q));
      end
    end
    for (int w = 0; w < NumWin; w++) begin
      delta[w] = total_q - last_q[w];
    end
  end

  // delta * (1000/window) * 8, wrapping
  assign entry_o.sample           = sample;
  assign entry_o.scaled[Win100ms] = (delta[Win100ms] << 6) + (delta[Win100ms] << 4);
  assign entry_o.scaled[Win500ms] = delta[Win500ms] << 4;
  assign entry_o.scaled[Win1s]    = delta[Win1s] << 3;
  assign entry_o.done             = done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_ms_q  <= '0;
      total_q   <= '0;
      elapsed_q <= '0;
      phase_q   <= '0;
      done_q    <= 1'b0;
      for (int w = 0; w < NumWin; w++) begin
        last_q[w] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        run_ms_q <= cfg_run_ms_i;
      end
      if (accept_i) begin
        total_q   <= total_d;
        elapsed_q <= elapsed_d;
        phase_q   <= phase_d;
        done_q    <= done_d;
        for (int w = 0; w < NumWin; w++) begin
          if (sample[w]) begin
            last_q[w] <= total_q;
          end
        end
      end
    end
  end

endmodule

>>> sv/tws_back.sv
// Back end: divides scaled deltas by 1000 through a registered reciprocal
// multiply, then updates min/max/average per window. Uses tws_pkg.
module tws_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tws_pkg::mid_entry_t  entry_i,
  input  logic                 entry_valid_i,
  output logic                 entry_pop_o,
  output tws_pkg::result_t     result_o,
  output logic                 result_push_o,
  input  logic                 result_full_i
);

  import tws_pkg::*;

  function automatic stats_t step_stats(stats_t s, logic [DataW-1:0] speed);
    stats_t r;
    logic [DataW-1:0] sum;
    r = s;
    if (s.lo == '0 && s.hi == '0 && s.avg == '0) begin
      r.lo  = speed;
      r.hi  = speed;
      r.avg = speed;
    end
    if (speed > r.hi) r.hi = speed;
    if (speed < r.lo) r.lo = speed;
    sum   = r.avg + speed;
    r.avg = sum >> 1;
    return r;
  endfunction

  logic                           s1_valid_q;
  logic [NumWin-1:0]              s1_sample_q;
  logic                           s1_done_q;
  logic [NumWin-1:0][SpeedW-1:0]  s1_speed_q;
  logic [NumWin-1:0][SpeedW-1:0]  speed_d;
  logic [2*DataW-1:0]             prod [NumWin];
  logic                           s1_ready;
  logic                           s1_move;
  stats_t                         stats_q [NumWin];
  stats_t                         stats_d [NumWin];

  assign s1_move     = s1_valid_q && !result_full_i;
  assign s1_ready    = !s1_valid_q || !result_full_i;
  assign entry_pop_o = s1_ready && entry_valid_i;

  always_comb begin
    for (int w = 0; w < NumWin; w++) begin
      prod[w]    = entry_i.scaled[w] * RecipMul;
      speed_d[w] = prod[w][2*DataW-1:RecipShift];
    end
  end

  always_comb begin
    for (int w = 0; w < NumWin; w++) begin
      stats_d[w] = s1_sample_q[w] ? step_stats(stats_q[w], DataW'(s1_speed_q[w]))
                                  : stats_q[w];
      result_o.win[w] = stats_d[w];
    end
    result_o.finished = s1_done_q;
  end

  assign result_push_o = s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      for (int w = 0; w < NumWin; w++) begin
        stats_q[w] <= '0;
      end
    end else begin
      if (s1_ready) begin
        s1_valid_q <= entry_valid_i;
      end
      if (s1_move) begin
        for (int w = 0; w < NumWin; w++) begin
          stats_q[w] <= stats_d[w];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      s1_sample_q <= entry_i.sample;
      s1_done_q   <= entry_i.done;
      s1_speed_q  <= speed_d;
    end
  end

endmodule

>>> sv/throughput_window_stats.sv
// Link throughput meter: byte and tick words in, min/max/average kbit/s for
// 100 ms, 500 ms and 1 s windows out. Uses tws_pkg, tws_front, tws_back, tws_fifo.
//
// One input word can be taken every cycle while full is low, and each word
// yields exactly one result word. An accepted word is written into the
// front-to-back queue, then moves into the reciprocal-multiply register that
// divides by 1000, then enters the result queue and shows on the result
// ports; each move waits while its destination is full. full rises only
// when results are not popped and the buffering has filled up. With the
// default depths that is five words: two in the front-to-back queue, one in
// the multiply register and two in the result queue. The run length register
// is written through the cfg channel, which is always ready; write it only
// while no words are in flight.
module throughput_window_stats #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tws_pkg::RunMsW-1:0]    cfg_run_ms_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          command_i,
  input  logic [tws_pkg::CountW-1:0]    byte_count_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [tws_pkg::DataW-1:0]     min_100ms_o,
  output logic [tws_pkg::DataW-1:0]     max_100ms_o,
  output logic [tws_pkg::DataW-1:0]     avg_100ms_o,
  output logic [tws_pkg::DataW-1:0]     min_500ms_o,
  output logic [tws_pkg::DataW-1:0]     max_500ms_o,
  output logic [tws_pkg::DataW-1:0]     avg_500ms_o,
  output logic [tws_pkg::DataW-1:0]     min_1s_o,
  output logic [tws_pkg::DataW-1:0]     max_1s_o,
  output logic [tws_pkg::DataW-1:0]     avg_1s_o,
  output logic                          finished_o
);

  import tws_pkg::*;

  localparam int unsigned MidW = $bits(mid_entry_t);
  localparam int unsigned ResW = $bits(result_t);

  mid_entry_t front_entry, back_entry;
  logic       accept;
  logic       mid_empty, mid_pop;
  result_t    back_result, out_result;
  logic       res_push, res_full;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  tws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_run_ms_i (cfg_run_ms_i),
    .accept_i     (accept),
    .command_i    (command_i),
    .byte_count_i (byte_count_i),
    .entry_o      (front_entry)
  );

  tws_fifo #(
    .Width (MidW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_entry),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (back_entry),
    .empty_o (mid_empty)
  );

  tws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (back_entry),
    .entry_valid_i (!mid_empty),
    .entry_pop_o   (mid_pop),
    .result_o      (back_result),
    .result_push_o (res_push),
    .result_full_i (res_full)
  );

  tws_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_result),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_result),
    .empty_o (empty)
  );

  assign min_100ms_o = out_result.win[Win100ms].lo;
  assign max_100ms_o = out_result.win[Win100ms].hi;
  assign avg_100ms_o = out_result.win[Win100ms].avg;
  assign min_500ms_o = out_result.win[Win500ms].lo;
  assign max_500ms_o = out_result.win[Win500ms].hi;
  assign avg_500ms_o = out_result.win[Win500ms].avg;
  assign min_1s_o    = out_result.win[Win1s].lo;
  assign max_1s_o    = out_result.win[Win1s].hi;
  assign avg_1s_o    = out_result.win[Win1s].avg;
  assign finished_o  = out_result.finished;

endmodule
